// ----- rtl/frls_pkg.sv -----
`default_nettype none

package frls_pkg;

  localparam int unsigned REC_WORDS_DEF = 4;
  localparam int unsigned REC_SLOTS_DEF = 256;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned OUT_WORDS     = 4;
  localparam int unsigned SLOT_OUT_W    = 8;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t WORD_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OC_READ      = 3'd0,
    OC_UNCHANGED = 3'd1,
    OC_IN_PLACE  = 3'd2,
    OC_APPENDED  = 3'd3,
    OC_ERASED    = 3'd4
  } outcome_e;

  // where the old contents of the target slot come from on a write
  typedef enum logic [1:0] {
    OLD_CUR   = 2'd0,
    OLD_EMPTY = 2'd1,
    OLD_ONES  = 2'd2
  } old_src_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_RD   = 3'd1,
    ST_CHK  = 3'd2,
    ST_CMP  = 3'd3,
    ST_DEC  = 3'd4,
    ST_WR   = 3'd5,
    ST_OUT  = 3'd6
  } state_e;

  typedef struct packed {
    logic     init;
    logic     rd;
    logic     chk;
    logic     live;
    logic     found;
    logic     wr;
    old_src_e src;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/frls_if.sv -----
`default_nettype none

interface frls_cmd_if;
  import frls_pkg::*;
  logic  valid;
  logic  ready;
  logic  command;
  word_t new_word_0;
  word_t new_word_1;
  word_t new_word_2;
  word_t new_word_3;

  modport source (output valid, command, new_word_0, new_word_1, new_word_2, new_word_3,
                  input ready);
  modport sink   (input valid, command, new_word_0, new_word_1, new_word_2, new_word_3,
                  output ready);
endinterface

interface frls_rsp_if;
  import frls_pkg::*;
  logic       valid;
  logic       ready;
  word_t      cur_word_0;
  word_t      cur_word_1;
  word_t      cur_word_2;
  word_t      cur_word_3;
  logic [2:0] outcome;
  logic [7:0] slot_used;

  modport source (output valid, cur_word_0, cur_word_1, cur_word_2, cur_word_3, outcome,
                  slot_used, input ready);
  modport sink   (input valid, cur_word_0, cur_word_1, cur_word_2, cur_word_3, outcome,
                  slot_used, output ready);
endinterface

`default_nettype wire

// ----- rtl/frls_lane.sv -----
`default_nettype none

module frls_lane import frls_pkg::*; #(
  parameter int unsigned REC_SLOTS = REC_SLOTS_DEF,
  localparam int unsigned ADDR_W   = $clog2(REC_SLOTS)
) (
  input  wire logic              clk_i,
  input  wire lane_ctrl_t        ctrl_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire word_t             new_i,
  output logic                   eff_ones_o,
  output word_t                  cur_o,
  output logic                   eq_o,
  output logic                   sub_o
);

  word_t mem_q [REC_SLOTS];
  word_t rd_q;
  word_t prev_q;
  word_t cur_q;
  word_t emp_q;
  word_t eff;
  word_t res;

  // slots at or above the fill mark read as erased
  assign eff        = ctrl_i.live ? rd_q : WORD_ONES;
  assign eff_ones_o = (eff == WORD_ONES);

  always_comb begin
    case (ctrl_i.src)
      OLD_CUR:   res = cur_q & new_i;
      OLD_EMPTY: res = emp_q & new_i;
      default:   res = new_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[addr_i] <= res;
    end
    if (ctrl_i.rd) begin
      rd_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      prev_q <= WORD_ONES;
    end else if (ctrl_i.chk) begin
      if (ctrl_i.found) begin
        cur_q <= prev_q;
        emp_q <= eff;
      end else begin
        prev_q <= eff;
        cur_q  <= eff;
      end
    end else if (ctrl_i.wr) begin
      cur_q <= res;
    end
  end

  assign cur_o = cur_q;
  assign eq_o  = (cur_q == new_i);
  assign sub_o = ((~cur_q & new_i) == '0);

endmodule

`default_nettype wire

// ----- rtl/frls_merge.sv -----
`default_nettype none

module frls_merge import frls_pkg::*; #(
  parameter int unsigned REC_WORDS = REC_WORDS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 cap_i,
  input  wire logic [REC_WORDS-1:0] eq_i,
  input  wire logic [REC_WORDS-1:0] sub_i,
  output logic                      same_o,
  output logic                      subset_o
);

  logic same_q;
  logic subset_q;

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      same_q   <= &eq_i;
      subset_q <= &sub_i;
    end
  end

  assign same_o   = same_q;
  assign subset_o = subset_q;

endmodule

`default_nettype wire

// ----- rtl/flash_record_log_store.sv -----
`default_nettype none

// One flash page kept as an append log of fixed-size records, with one memory
// lane per record word. Every command scans slots from 0, each slot with a memory
// read, then an empty check on word 0, until the first empty slot or the end of
// the page, so the scan length sets how long a command runs. A command is taken
// only in the idle state, once the last result has gone into the output register.
// Page erase is a reset of the fill mark, which tracks how many slots were written
// since the last erase; slots at or above it read as all ones, so no clearing
// pass runs after reset. A result waits in an output register; the next command
// is taken while it waits.

module flash_record_log_store import frls_pkg::*; #(
  parameter int unsigned REC_WORDS = REC_WORDS_DEF,
  parameter int unsigned REC_SLOTS = REC_SLOTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  frls_cmd_if.sink   cmd_ch,
  frls_rsp_if.source rsp_ch
);

  localparam int unsigned ADDR_W = $clog2(REC_SLOTS);
  localparam int unsigned SLOT_W = $clog2(REC_SLOTS + 1);

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   scan_q, scan_d;
  logic [SLOT_W-1:0]   empty_q, empty_d;
  logic [SLOT_W-1:0]   hw_q, hw_d;
  logic [ADDR_W-1:0]   pos_q, pos_d;
  outcome_e            outc_q, outc_d;
  old_src_e            src_q, src_d;
  logic                cmd_q;
  word_t               new_q [OUT_WORDS];

  logic                rsp_valid_q, rsp_valid_d;
  word_t               rsp_word_q [OUT_WORDS];
  outcome_e            rsp_outc_q;
  logic [SLOT_OUT_W-1:0] rsp_slot_q;

  lane_ctrl_t            lctrl;
  logic [ADDR_W-1:0]     addr;
  logic [REC_WORDS-1:0]  eff_ones;
  logic [REC_WORDS-1:0]  eq_v;
  logic [REC_WORDS-1:0]  sub_v;
  word_t                 lane_cur [REC_WORDS];
  word_t                 out_rec  [OUT_WORDS];
  logic                  same;
  logic                  subset;
  logic                  accept;
  logic                  load_out;
  logic                  erase;
  logic [ADDR_W-1:0]     cur_slot;
  logic [SLOT_W-1:0]     pos_next;

  assign cmd_ch.ready = (state_q == ST_IDLE);
  assign accept       = cmd_ch.valid && cmd_ch.ready;
  assign load_out     = (state_q == ST_OUT) && (!rsp_valid_q || rsp_ch.ready);

  // scan outcome: a full page, or a last empty slot, forces an erase
  assign erase    = (empty_q >= SLOT_W'(REC_SLOTS - 1));
  assign cur_slot = (empty_q == '0) ? '0 : ADDR_W'(empty_q - SLOT_W'(1));
  assign pos_next = SLOT_W'(pos_q) + SLOT_W'(1);

  assign addr = (state_q == ST_WR) ? pos_q : scan_q;

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    empty_d      = empty_q;
    hw_d         = hw_q;
    pos_d        = pos_q;
    outc_d       = outc_q;
    src_d        = src_q;
    lctrl        = '0;
    lctrl.src    = src_q;
    lctrl.live   = (SLOT_W'(scan_q) < hw_q);
    lctrl.found  = eff_ones[0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          lctrl.init = 1'b1;
          scan_d     = '0;
          state_d    = ST_RD;
        end
      end
      ST_RD: begin
        lctrl.rd = 1'b1;
        state_d  = ST_CHK;
      end
      ST_CHK: begin
        lctrl.chk = 1'b1;
        if (eff_ones[0]) begin
          empty_d = SLOT_W'(scan_q);
          state_d = ST_CMP;
        end else if (scan_q == ADDR_W'(REC_SLOTS - 1)) begin
          // no empty slot: current record is the last slot
          empty_d = SLOT_W'(REC_SLOTS);
          state_d = ST_CMP;
        end else begin
          scan_d  = scan_q + ADDR_W'(1);
          state_d = ST_RD;
        end
      end
      ST_CMP: begin
        state_d = ST_DEC;
      end
      ST_DEC: begin
        pos_d   = cur_slot;
        state_d = ST_OUT;
        if (!cmd_q) begin
          outc_d = OC_READ;
        end else if (same) begin
          outc_d = OC_UNCHANGED;
        end else begin
          state_d = ST_WR;
          if (erase) begin
            // erase is a reset of the fill mark, slot 0 is rewritten next
            pos_d  = '0;
            src_d  = OLD_ONES;
            outc_d = OC_ERASED;
          end else if (empty_q == '0) begin
            pos_d  = '0;
            src_d  = OLD_EMPTY;
            outc_d = OC_APPENDED;
          end else if (subset) begin
            src_d  = OLD_CUR;
            outc_d = OC_IN_PLACE;
          end else begin
            pos_d  = ADDR_W'(empty_q);
            src_d  = OLD_EMPTY;
            outc_d = OC_APPENDED;
          end
        end
      end
      ST_WR: begin
        lctrl.wr = 1'b1;
        if (outc_q == OC_ERASED) begin
          hw_d = SLOT_W'(1);
        end else if (pos_next > hw_q) begin
          hw_d = pos_next;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (load_out) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ch.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hw_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    empty_q <= empty_d;
    pos_q   <= pos_d;
    outc_q  <= outc_d;
    src_q   <= src_d;
    if (accept) begin
      cmd_q    <= cmd_ch.command;
      new_q[0] <= cmd_ch.new_word_0;
      new_q[1] <= cmd_ch.new_word_1;
      new_q[2] <= cmd_ch.new_word_2;
      new_q[3] <= cmd_ch.new_word_3;
    end
    if (load_out) begin
      rsp_word_q <= out_rec;
      rsp_outc_q <= outc_q;
      rsp_slot_q <= SLOT_OUT_W'(pos_q);
    end
  end

  // one lane per record word
  for (genvar k = 0; k < REC_WORDS; k++) begin : g_lane
    frls_lane #(
      .REC_SLOTS (REC_SLOTS)
    ) u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (lctrl),
      .addr_i     (addr),
      .new_i      (new_q[k]),
      .eff_ones_o (eff_ones[k]),
      .cur_o      (lane_cur[k]),
      .eq_o       (eq_v[k]),
      .sub_o      (sub_v[k])
    );
  end

  // words past the record length read as zero
  for (genvar k = 0; k < OUT_WORDS; k++) begin : g_out
    if (k < REC_WORDS) begin : g_used
      assign out_rec[k] = lane_cur[k];
    end else begin : g_pad
      assign out_rec[k] = '0;
    end
  end

  frls_merge #(
    .REC_WORDS (REC_WORDS)
  ) u_merge (
    .clk_i    (clk_i),
    .cap_i    (state_q == ST_CMP),
    .eq_i     (eq_v),
    .sub_i    (sub_v),
    .same_o   (same),
    .subset_o (subset)
  );

  assign rsp_ch.valid      = rsp_valid_q;
  assign rsp_ch.cur_word_0 = rsp_word_q[0];
  assign rsp_ch.cur_word_1 = rsp_word_q[1];
  assign rsp_ch.cur_word_2 = rsp_word_q[2];
  assign rsp_ch.cur_word_3 = rsp_word_q[3];
  assign rsp_ch.outcome    = rsp_outc_q;
  assign rsp_ch.slot_used  = rsp_slot_q;

  // fill mark never passes the page size
  a_hw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= SLOT_W'(REC_SLOTS))
    else $error("fill mark beyond page");

  // after a write, the slot just written is covered by the fill mark
  a_wr_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |=> (SLOT_W'(pos_q) < hw_q))
    else $error("written slot outside fill mark");

  // a new result only appears out of the output state
  a_rsp_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result without finished command");

  // an erase always lands in slot 0
  a_erase_slot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_outc_q == OC_ERASED)) |-> (rsp_slot_q == '0))
    else $error("erase result not at slot 0");

endmodule

`default_nettype wire

// ----- verif/tb_flash_record_log_store.sv -----
`default_nettype none

module tb_flash_record_log_store;
  import frls_pkg::*;

  localparam int unsigned SLOTS        = REC_SLOTS_DEF;
  localparam logic        CMD_READ     = 1'b0;
  localparam logic        CMD_UPDATE   = 1'b1;
  localparam int unsigned RANDOM_ITEMS = 440;
  // worst case scan of a full page plus write and output stages
  localparam int unsigned SCAN_CYCLES  = 2 * SLOTS + 8;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef word_t [OUT_WORDS-1:0] record_t;

  typedef struct packed {
    record_t    words;
    outcome_e   outcome;
    logic [7:0] slot;
  } log_result_t;

  // flavors of generated commands
  typedef enum int {
    K_READ,
    K_SAME,
    K_CLEAR,
    K_FRESH,
    K_BLANK_HEAD
  } stim_kind_e;

  // page image kept in step with every accepted command, plus the queue of
  // results the block still owes
  class record_log_scoreboard;
    record_t     page [REC_SLOTS_DEF];
    log_result_t owed_q [$];
    int unsigned failures;
    int unsigned noted;
    int unsigned outcome_seen [5];

    function new();
      failures = 0;
      noted    = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
      clear_image();
    endfunction

    function void clear_image();
      foreach (page[s]) page[s] = {OUT_WORDS{WORD_ONES}};
    endfunction

    // first slot whose head word is erased, or the slot count if none
    function int unsigned first_blank();
      for (int unsigned s = 0; s < REC_SLOTS_DEF; s++) begin
        if (page[s][0] == WORD_ONES) return s;
      end
      return REC_SLOTS_DEF;
    endfunction

    function record_t current_record();
      int unsigned blank;
      blank = first_blank();
      if (blank == 0) return {OUT_WORDS{WORD_ONES}};
      return page[blank-1];
    endfunction

    // words past the configured record width read as zero
    function record_t visible(record_t r);
      record_t v;
      v = '0;
      for (int unsigned k = 0; k < REC_WORDS_DEF; k++) v[k] = r[k];
      return v;
    endfunction

    function void owe(record_t r, outcome_e oc, int unsigned slot);
      log_result_t res;
      res.words   = visible(r);
      res.outcome = oc;
      res.slot    = slot[7:0];
      owed_q.push_back(res);
    endfunction

    function void note_cmd(bit update, record_t rec);
      int unsigned blank;
      int unsigned cur_slot;
      int unsigned pos;
      record_t     cur;
      bit          same;
      bit          subset;
      outcome_e    oc;
      noted++;
      blank    = first_blank();
      cur_slot = (blank == 0) ? 0 : blank - 1;
      cur      = current_record();
      if (!update) begin
        owe(cur, OC_READ, cur_slot);
        return;
      end
      same   = 1'b1;
      subset = 1'b1;
      for (int unsigned k = 0; k < REC_WORDS_DEF; k++) begin
        if (cur[k] != rec[k]) same = 1'b0;
        if ((~cur[k] & rec[k]) != '0) subset = 1'b0;
      end
      if (same) begin
        owe(cur, OC_UNCHANGED, cur_slot);
        return;
      end
      if (blank == 0) begin
        pos = 0;
        oc  = OC_APPENDED;
      end else if (subset) begin
        pos = blank - 1;
        oc  = OC_IN_PLACE;
      end else begin
        pos = blank;
        oc  = OC_APPENDED;
      end
      if (blank >= REC_SLOTS_DEF - 1) begin
        clear_image();
        pos = 0;
        oc  = OC_ERASED;
      end
      // programming only clears bits
      for (int unsigned k = 0; k < REC_WORDS_DEF; k++) page[pos][k] &= rec[k];
      owe(page[pos], oc, pos);
    endfunction

    function void check_rsp(log_result_t got);
      log_result_t want;
      bit          bad;
      if (owed_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("ERROR: unexpected result words=%h outcome=%0d slot=%0d",
                   got.words, got.outcome, got.slot);
        return;
      end
      want = owed_q.pop_front();
      bad  = 1'b0;
      for (int k = 0; k < OUT_WORDS; k++) begin
        if (got.words[k] !== want.words[k]) bad = 1'b1;
      end
      if (got.outcome !== want.outcome) bad = 1'b1;
      if (got.slot !== want.slot) bad = 1'b1;
      if (bad) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display({"ERROR: result mismatch exp words=%h outcome=%0d slot=%0d,",
                    " got words=%h outcome=%0d slot=%0d"},
                   want.words, want.outcome, want.slot, got.words, got.outcome, got.slot);
      end else begin
        outcome_seen[want.outcome]++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  frls_cmd_if cmd_ch ();
  frls_rsp_if rsp_ch ();

  flash_record_log_store #(
    .REC_WORDS(REC_WORDS_DEF),
    .REC_SLOTS(REC_SLOTS_DEF)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_ch(cmd_ch),
    .rsp_ch(rsp_ch)
  );

  record_log_scoreboard log_sb = new();

  // idle percentages for the current phase
  int unsigned src_idle_pct  = 0;
  int unsigned rsp_stall_pct = 0;
  // sender asks the receiver for one long hold-off
  bit          hold_req      = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // varied word values: zeros, ones, a single set bit, or random
  function automatic word_t rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return WORD_ONES;
      2:       return word_t'(1) << $urandom_range(31);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic record_t rec4(word_t w0, word_t w1, word_t w2, word_t w3);
    record_t r;
    r[0] = w0;
    r[1] = w1;
    r[2] = w2;
    r[3] = w3;
    return r;
  endfunction

  // build a record relative to what the page holds after all accepted commands
  function automatic record_t make_record(stim_kind_e kind);
    record_t cur;
    record_t r;
    cur = log_sb.current_record();
    for (int k = 0; k < OUT_WORDS; k++) r[k] = rand_word();
    case (kind)
      K_SAME: begin
        r = cur;
      end
      K_CLEAR: begin
        for (int k = 0; k < OUT_WORDS; k++) r[k] = cur[k] & rand_word();
      end
      K_BLANK_HEAD: begin
        r[0] = WORD_ONES;
      end
      K_FRESH: begin
        // head word must not look erased so the log really grows
        if (r[0] == WORD_ONES) r[0] = word_t'($urandom_range(32'hFFFF_FFFE, 0));
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // present one command at a falling edge, hold it until the transfer
  task automatic send_cmd(logic cmd, record_t rec);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= cmd;
    cmd_ch.new_word_0 <= rec[0];
    cmd_ch.new_word_1 <= rec[1];
    cmd_ch.new_word_2 <= rec[2];
    cmd_ch.new_word_3 <= rec[3];
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    log_sb.note_cmd(cmd == CMD_UPDATE, rec);
  endtask

  task automatic send_kind(stim_kind_e kind);
    send_cmd((kind == K_READ) ? CMD_READ : CMD_UPDATE, make_record(kind));
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (log_sb.pending() != 0) @(posedge clk_i);
  endtask

  // response side: random stalls, plus one long hold-off counted here
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // sample every result transfer at the rising edge
  always @(posedge clk_i) begin
    log_result_t got;
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.words[0] = rsp_ch.cur_word_0;
      got.words[1] = rsp_ch.cur_word_1;
      got.words[2] = rsp_ch.cur_word_2;
      got.words[3] = rsp_ch.cur_word_3;
      got.outcome  = outcome_e'(rsp_ch.outcome);
      got.slot     = rsp_ch.slot_used;
      log_sb.check_rsp(got);
    end
  end

  initial begin
    stim_kind_e  kind;
    int unsigned pick;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.command    <= CMD_READ;
    cmd_ch.new_word_0 <= '0;
    cmd_ch.new_word_1 <= '0;
    cmd_ch.new_word_2 <= '0;
    cmd_ch.new_word_3 <= '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty page read, then no-op update of an all-ones record
    send_cmd(CMD_READ, '0);
    send_cmd(CMD_UPDATE, {OUT_WORDS{WORD_ONES}});
    // record with an erased head word lands in slot 0 but leaves it blank
    send_cmd(CMD_UPDATE, rec4(WORD_ONES, 32'h0, 32'h1234_5678, WORD_ONES));
    send_cmd(CMD_UPDATE, rec4(32'hDEAD_BEEF, 32'h0F0F_0F0F, 32'hFFFF_0000, 32'h8000_0001));
    send_cmd(CMD_READ, {OUT_WORDS{WORD_ONES}});
    send_kind(K_SAME);
    send_kind(K_CLEAR);
    // all zeros only clears bits: rewritten in place, then unchanged
    send_cmd(CMD_UPDATE, '0);
    send_cmd(CMD_UPDATE, '0);
    // all ones cannot be programmed over zeros, so it is appended
    send_cmd(CMD_UPDATE, {OUT_WORDS{WORD_ONES}});
    send_cmd(CMD_READ, '0);
    send_cmd(CMD_UPDATE, {OUT_WORDS{32'hAAAA_AAAA}});
    send_cmd(CMD_UPDATE, {OUT_WORDS{32'h5555_5555}});
    send_cmd(CMD_UPDATE, rec4(32'h0, WORD_ONES, 32'h0, WORD_ONES));
    send_cmd(CMD_UPDATE, '0);
    repeat (4) send_kind(K_FRESH);
    send_kind(K_BLANK_HEAD);
    send_kind(K_CLEAR);
    send_kind(K_SAME);
    send_kind(K_READ);

    // random part, mostly appends so the page fills and gets erased
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      case (i)
        0:   begin src_idle_pct = 0;  rsp_stall_pct = 0;  end
        110: begin src_idle_pct = 80; rsp_stall_pct = 0;  end
        220: begin src_idle_pct = 0;  rsp_stall_pct = 80; end
        330: begin src_idle_pct = 30; rsp_stall_pct = 30; end
        default: begin
        end
      endcase
      // long receiver hold-off while commands keep coming
      if (i == 60) hold_req = 1'b1;
      // one full pause until the block has caught up
      if (i == 200) drain();
      pick = $urandom_range(99);
      if (pick < 10)      kind = K_READ;
      else if (pick < 17) kind = K_SAME;
      else if (pick < 30) kind = K_CLEAR;
      else if (pick < 33) kind = K_BLANK_HEAD;
      else                kind = K_FRESH;
      send_kind(kind);
    end

    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    rsp_stall_pct = 0;
    while (log_sb.pending() != 0) @(posedge clk_i);
    // watch for stray results after the last one
    repeat (SCAN_CYCLES) @(posedge clk_i);

    $display({"run: %0d commands: %0d reads, %0d unchanged, %0d in place,",
              " %0d appended, %0d erases"},
             log_sb.noted, log_sb.outcome_seen[OC_READ], log_sb.outcome_seen[OC_UNCHANGED],
             log_sb.outcome_seen[OC_IN_PLACE], log_sb.outcome_seen[OC_APPENDED],
             log_sb.outcome_seen[OC_ERASED]);
    $display("run: idle phases on both sides, a %0d cycle response hold-off and a full drain",
             HOLD_CYCLES);
    if (log_sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("run: %0d failures", log_sb.failures);
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(4 * LIMIT_CYCLES);
    $display("run: timeout with %0d results outstanding", log_sb.pending());
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
